### src/ordtbl_pkg.sv
package ordtbl_pkg;

	// Operation codes carried on the operation port
	typedef enum logic [1:0] {
		OP_SEARCH = 2'd0,
		OP_REMOVE = 2'd1,
		OP_INSERT = 2'd2,
		OP_UNUSED = 2'd3
	} op_t;

	// Result status codes
	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_FULL      = 2'd2,
		ST_BAD_POS   = 2'd3
	} status_t;

	localparam int VALUE_W = 32;
	localparam int POS_W   = 5;
	localparam int INDEX_W = 5;
	localparam int COUNT_W = 5;

	// Index reported when there is no match or the operation is refused
	localparam logic [INDEX_W-1:0] NO_INDEX = '1;

	// Control word broadcast to every cell in the row
	typedef struct packed {
		logic                 cmp;    // latch equality hit for the current value
		logic                 walk;   // move hit flags one cell toward cell 0
		logic                 ins;    // open a slot and write value
		logic                 rem;    // close the gap over a removed entry
		logic [VALUE_W-1:0]   value;
	} cell_ctl_t;

endpackage

### src/ordtbl_cell.sv
module ordtbl_cell #(
	parameter int IDX   = 0,
	parameter int CNT_W = 5,
	parameter int POS_W = 5
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  ordtbl_pkg::cell_ctl_t         ctl,
	input  logic [CNT_W-1:0]              count,
	input  logic [CNT_W-1:0]              rem_index,
	input  logic [POS_W-1:0]              ins_pos,
	input  logic [ordtbl_pkg::VALUE_W-1:0] lower_entry,
	input  logic [ordtbl_pkg::VALUE_W-1:0] upper_entry,
	input  logic                          upper_hit,
	output logic [ordtbl_pkg::VALUE_W-1:0] entry,
	output logic                          hit
);

	logic [ordtbl_pkg::VALUE_W-1:0] entry_q;
	logic                           hit_q;
	logic                           in_use;
	logic                           above_pos;
	logic                           at_pos;
	logic                           above_rem;

	// Position of this cell relative to the count and the operation indexes
	assign in_use    = CNT_W'(IDX) < count;
	assign above_pos = POS_W'(IDX) > ins_pos;
	assign at_pos    = POS_W'(IDX) == ins_pos;
	assign above_rem = CNT_W'(IDX) >= rem_index;

	// Match flag: loaded by the compare, then handed down the row
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= 1'b0;
		end else if (ctl.cmp) begin
			hit_q <= in_use && (entry_q == ctl.value);
		end else if (ctl.walk) begin
			hit_q <= upper_hit;
		end
	end

	// Stored entry: shifts up on insert, down on remove
	always_ff @(posedge clk) begin
		if (ctl.ins) begin
			if (above_pos) begin
				entry_q <= lower_entry;
			end else if (at_pos) begin
				entry_q <= ctl.value;
			end
		end else if (ctl.rem && above_rem) begin
			entry_q <= upper_entry;
		end
	end

	assign entry = entry_q;
	assign hit   = hit_q;

endmodule

### src/ordered_table_insert_remove_search_core.sv
// Channel   Ports                                      Handshake
// -------   ----------------------------------------   -----------------------------
// command   operation, value, insert_position          start high while busy low
// result    status, found_index, entry_count           done high for one cycle
//
// Insert and unused codes: the command passes through the compare state, then the
// result strobe is raised as the sequencer returns to idle. Search and remove: every
// cell compares at once, then the match flags move one cell per cycle toward cell 0,
// and the walk ends at the match index (or at the fill count when nothing matches).
// The next command may be taken in the cycle that shows the strobe. Reset empties
// the table at once; the receiver cannot stall results.
module ordered_table_insert_remove_search_core #(
	parameter int TABLE_DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  operation,
	input  logic [31:0] value,
	input  logic [4:0]  insert_position,
	output logic        done,
	output logic [1:0]  status,
	output logic [4:0]  found_index,
	output logic [4:0]  entry_count
);

	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
	localparam int CMP_W = (CNT_W > ordtbl_pkg::POS_W) ? CNT_W : ordtbl_pkg::POS_W;

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_CMP  = 3'b010,
		S_WALK = 3'b100
	} state_t;

	state_t                          state_q;
	ordtbl_pkg::op_t                 op_q;
	logic [ordtbl_pkg::VALUE_W-1:0]  value_q;
	logic [ordtbl_pkg::POS_W-1:0]    pos_q;
	logic [CNT_W-1:0]                count_q;
	logic [CNT_W-1:0]                step_q;
	logic                            done_q;
	ordtbl_pkg::status_t             status_q;
	logic [ordtbl_pkg::INDEX_W-1:0]  index_q;

	ordtbl_pkg::cell_ctl_t           ctl;
	logic [ordtbl_pkg::VALUE_W-1:0]  entries [TABLE_DEPTH];
	logic [TABLE_DEPTH-1:0]          hits;
	logic [CMP_W-1:0]                pos_ext;
	logic                            accept;
	logic                            table_full;
	logic                            pos_bad;
	logic                            is_lookup;
	logic                            walk_end;

	assign accept     = start && (state_q == S_IDLE);
	assign table_full = count_q >= CNT_W'(TABLE_DEPTH);
	assign pos_ext    = CMP_W'(pos_q);
	assign pos_bad    = pos_ext > CMP_W'(count_q);
	assign is_lookup  = (op_q == ordtbl_pkg::OP_SEARCH) || (op_q == ordtbl_pkg::OP_REMOVE);
	assign walk_end   = (step_q == count_q) || hits[0];

	// Control word for the row of cells
	always_comb begin
		ctl       = '0;
		ctl.value = value_q;
		ctl.cmp   = (state_q == S_CMP) && is_lookup;
		ctl.ins   = (state_q == S_CMP) && (op_q == ordtbl_pkg::OP_INSERT)
		            && !table_full && !pos_bad;
		ctl.walk  = (state_q == S_WALK) && !walk_end;
		ctl.rem   = (state_q == S_WALK) && (step_q != count_q) && hits[0]
		            && (op_q == ordtbl_pkg::OP_REMOVE);
	end

	// Row of cells; each hands its entry and match flag to its neighbors
	for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
		logic [ordtbl_pkg::VALUE_W-1:0] lower_e;
		logic [ordtbl_pkg::VALUE_W-1:0] upper_e;
		logic                           upper_h;

		if (i == 0) begin : g_bottom
			assign lower_e = value_q;
		end else begin : g_mid_lo
			assign lower_e = entries[i-1];
		end

		if (i == TABLE_DEPTH - 1) begin : g_top
			assign upper_e = entries[i];
			assign upper_h = 1'b0;
		end else begin : g_mid_hi
			assign upper_e = entries[i+1];
			assign upper_h = hits[i+1];
		end

		ordtbl_cell #(
			.IDX   (i),
			.CNT_W (CNT_W),
			.POS_W (CMP_W)
		) u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctl         (ctl),
			.count       (count_q),
			.rem_index   (step_q),
			.ins_pos     (pos_ext),
			.lower_entry (lower_e),
			.upper_entry (upper_e),
			.upper_hit   (upper_h),
			.entry       (entries[i]),
			.hit         (hits[i])
		);
	end

	// Command word capture
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q    <= ordtbl_pkg::op_t'(operation);
			value_q <= value;
			pos_q   <= insert_position;
		end
	end

	// Sequencer, fill count and result word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			count_q  <= '0;
			step_q   <= '0;
			done_q   <= 1'b0;
			status_q <= ordtbl_pkg::ST_OK;
			index_q  <= ordtbl_pkg::NO_INDEX;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_CMP;
					end
				end
				S_CMP: begin
					step_q <= '0;
					if (is_lookup) begin
						state_q <= S_WALK;
					end else begin
						state_q <= S_IDLE;
						done_q  <= 1'b1;
						index_q <= ordtbl_pkg::NO_INDEX;
						if (op_q != ordtbl_pkg::OP_INSERT) begin
							status_q <= ordtbl_pkg::ST_BAD_POS;
						end else if (table_full) begin
							status_q <= ordtbl_pkg::ST_FULL;
						end else if (pos_bad) begin
							status_q <= ordtbl_pkg::ST_BAD_POS;
						end else begin
							status_q <= ordtbl_pkg::ST_OK;
							index_q  <= ordtbl_pkg::INDEX_W'(pos_q);
							count_q  <= count_q + 1'b1;
						end
					end
				end
				S_WALK: begin
					if (step_q == count_q) begin
						state_q  <= S_IDLE;
						done_q   <= 1'b1;
						status_q <= ordtbl_pkg::ST_NOT_FOUND;
						index_q  <= ordtbl_pkg::NO_INDEX;
					end else if (hits[0]) begin
						state_q  <= S_IDLE;
						done_q   <= 1'b1;
						status_q <= ordtbl_pkg::ST_OK;
						index_q  <= ordtbl_pkg::INDEX_W'(step_q);
						if (op_q == ordtbl_pkg::OP_REMOVE) begin
							count_q <= count_q - 1'b1;
						end
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy        = (state_q != S_IDLE);
	assign done        = done_q;
	assign status      = status_q;
	assign found_index = index_q;
	assign entry_count = ordtbl_pkg::COUNT_W'(count_q);

endmodule

### sim/ordered_table_insert_remove_search_core_tb.sv
`timescale 1ns / 1ps

module ordered_table_insert_remove_search_core_tb;

	localparam int TBL_DEPTH = 16;
	localparam int RAND_PER_PHASE = 306;
	localparam int DRAIN_CYCLES = 40;

	typedef struct packed {
		ordtbl_pkg::status_t st;
		logic [4:0]          idx;
		logic [4:0]          cnt;
	} word_result_t;

	typedef struct {
		ordtbl_pkg::op_t op;
		logic [31:0]     v;
		logic [4:0]      pos;
		bit              typed;
		word_result_t    want;
	} dir_row_t;

	localparam word_result_t NO_WANT = '{ordtbl_pkg::ST_OK, 5'd0, 5'd0};

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [1:0]  operation;
	logic [31:0] value;
	logic [4:0]  insert_position;
	logic        done;
	logic [1:0]  status;
	logic [4:0]  found_index;
	logic [4:0]  entry_count;

	// shadow copy of the table, advanced on every accepted word
	logic [31:0]  shadow_vals [TBL_DEPTH];
	int           shadow_cnt;
	logic [31:0]  value_pool [8];
	word_result_t owed_results [$];
	dir_row_t     dir_rows [28];

	int err_cnt;
	int n_search, n_remove, n_insert, n_unused;
	int n_ok, n_miss, n_full, n_badpos;

	ordered_table_insert_remove_search_core #(
		.TABLE_DEPTH(TBL_DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.operation(operation),
		.value(value),
		.insert_position(insert_position),
		.done(done),
		.status(status),
		.found_index(found_index),
		.entry_count(entry_count)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	// apply one word to the shadow table and return what the block should report
	function automatic word_result_t shadow_apply(ordtbl_pkg::op_t op, logic [31:0] v,
			logic [4:0] p);
		word_result_t r;
		int hit;
		r.st = ordtbl_pkg::ST_BAD_POS;
		r.idx = ordtbl_pkg::NO_INDEX;
		hit = -1;
		case (op)
			ordtbl_pkg::OP_SEARCH, ordtbl_pkg::OP_REMOVE: begin
				for (int i = 0; i < shadow_cnt; i++)
					if (hit < 0 && shadow_vals[i] == v)
						hit = i;
				if (hit < 0) begin
					r.st = ordtbl_pkg::ST_NOT_FOUND;
				end else begin
					r.st = ordtbl_pkg::ST_OK;
					r.idx = 5'(hit);
					if (op == ordtbl_pkg::OP_REMOVE) begin
						for (int i = hit; i < shadow_cnt - 1; i++)
							shadow_vals[i] = shadow_vals[i + 1];
						shadow_cnt--;
					end
				end
			end
			ordtbl_pkg::OP_INSERT: begin
				if (shadow_cnt >= TBL_DEPTH) begin
					r.st = ordtbl_pkg::ST_FULL;
				end else if (int'(p) > shadow_cnt) begin
					r.st = ordtbl_pkg::ST_BAD_POS;
				end else begin
					for (int i = shadow_cnt; i > int'(p); i--)
						shadow_vals[i] = shadow_vals[i - 1];
					shadow_vals[int'(p)] = v;
					shadow_cnt++;
					r.st = ordtbl_pkg::ST_OK;
					r.idx = p;
				end
			end
			default: ;
		endcase
		r.cnt = 5'(shadow_cnt);
		return r;
	endfunction

	// mostly values already in the table, so searches and removes hit
	function automatic logic [31:0] pick_value();
		if (shadow_cnt > 0 && $urandom_range(99) < 70)
			return shadow_vals[$urandom_range(shadow_cnt - 1)];
		else if ($urandom_range(1) == 1)
			return value_pool[$urandom_range(7)];
		else
			return $urandom;
	endfunction

	task automatic pick_word(output ordtbl_pkg::op_t op, output logic [31:0] v,
			output logic [4:0] p);
		int r;
		int ins_pct;
		ins_pct = (shadow_cnt < 8) ? 50 : ((shadow_cnt < 14) ? 35 : 22);
		r = $urandom_range(99);
		v = pick_value();
		p = 5'($urandom_range(shadow_cnt));
		if (r < ins_pct) begin
			op = ordtbl_pkg::OP_INSERT;
		end else if (r < ins_pct + (100 - ins_pct) * 4 / 10) begin
			op = ordtbl_pkg::OP_SEARCH;
		end else if (r < 93) begin
			op = ordtbl_pkg::OP_REMOVE;
		end else if (r < 96) begin
			op = ordtbl_pkg::OP_UNUSED;
			p = 5'($urandom);
		end else begin
			// insert past the end of the list
			op = ordtbl_pkg::OP_INSERT;
			p = 5'($urandom_range(shadow_cnt + 1, 31));
		end
		if (op != ordtbl_pkg::OP_INSERT)
			p = 5'($urandom);
		if ($urandom_range(39) == 0)
			value_pool[$urandom_range(7)] = $urandom;
	endtask

	// called at a falling edge; returns at the falling edge after acceptance
	task automatic send_word(input ordtbl_pkg::op_t op, input logic [31:0] v,
			input logic [4:0] p, input bit typed, input word_result_t want);
		word_result_t pred;
		start <= 1'b1;
		operation <= op;
		value <= v;
		insert_position <= p;
		do
			@(posedge clk);
		while (busy);
		pred = shadow_apply(op, v, p);
		owed_results.push_back(typed ? want : pred);
		case (op)
			ordtbl_pkg::OP_SEARCH: n_search++;
			ordtbl_pkg::OP_REMOVE: n_remove++;
			ordtbl_pkg::OP_INSERT: n_insert++;
			default:               n_unused++;
		endcase
		@(negedge clk);
	endtask

	task automatic sender_gap(input int pct);
		while ($urandom_range(99) < pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
	endtask

	// result checker
	always @(posedge clk) begin : result_check
		word_result_t want;
		if (arst_n && done) begin
			case (ordtbl_pkg::status_t'(status))
				ordtbl_pkg::ST_OK:        n_ok++;
				ordtbl_pkg::ST_NOT_FOUND: n_miss++;
				ordtbl_pkg::ST_FULL:      n_full++;
				default:                  n_badpos++;
			endcase
			if (owed_results.size() == 0) begin
				err_cnt++;
				$display("%0t: result word with none owed: status %0d index %0d count %0d",
					$time, status, $signed(found_index), entry_count);
			end else begin
				want = owed_results.pop_front();
				if (status !== want.st || found_index !== want.idx
						|| entry_count !== want.cnt) begin
					err_cnt++;
					$display("%0t: expected status %0d index %0d count %0d, got %0d %0d %0d",
						$time, want.st, $signed(want.idx), want.cnt,
						status, $signed(found_index), entry_count);
				end
			end
		end
	end

	initial begin
		#10_000_000;
		$display("[ordered_table_insert_remove_search_core] ERROR");
		$finish;
	end

	initial begin
		ordtbl_pkg::op_t op;
		logic [31:0]     v;
		logic [4:0]      p;
		int              idle_pct;

		arst_n = 1'b0;
		start = 1'b0;
		operation = ordtbl_pkg::OP_SEARCH;
		value = '0;
		insert_position = '0;
		shadow_cnt = 0;
		err_cnt = 0;
		n_search = 0;
		n_remove = 0;
		n_insert = 0;
		n_unused = 0;
		n_ok = 0;
		n_miss = 0;
		n_full = 0;
		n_badpos = 0;
		foreach (shadow_vals[i])
			shadow_vals[i] = '0;
		foreach (value_pool[i])
			value_pool[i] = $urandom;

		// empty table errors, extremes, duplicates, fill to full, full-table cases
		dir_rows = '{
			'{ordtbl_pkg::OP_SEARCH, 32'h0000_0000, 5'd0,  1'b1,
				'{ordtbl_pkg::ST_NOT_FOUND, ordtbl_pkg::NO_INDEX, 5'd0}},
			'{ordtbl_pkg::OP_REMOVE, 32'h0000_0000, 5'd0,  1'b1,
				'{ordtbl_pkg::ST_NOT_FOUND, ordtbl_pkg::NO_INDEX, 5'd0}},
			'{ordtbl_pkg::OP_INSERT, 32'h0000_0007, 5'd1,  1'b1,
				'{ordtbl_pkg::ST_BAD_POS, ordtbl_pkg::NO_INDEX, 5'd0}},
			'{ordtbl_pkg::OP_UNUSED, 32'h0000_0005, 5'd0,  1'b1,
				'{ordtbl_pkg::ST_BAD_POS, ordtbl_pkg::NO_INDEX, 5'd0}},
			'{ordtbl_pkg::OP_INSERT, 32'h8000_0000, 5'd0,  1'b1,
				'{ordtbl_pkg::ST_OK, 5'd0, 5'd1}},
			'{ordtbl_pkg::OP_INSERT, 32'h7FFF_FFFF, 5'd1,  1'b1,
				'{ordtbl_pkg::ST_OK, 5'd1, 5'd2}},
			'{ordtbl_pkg::OP_INSERT, 32'hFFFF_FFFF, 5'd31, 1'b1,
				'{ordtbl_pkg::ST_BAD_POS, ordtbl_pkg::NO_INDEX, 5'd2}},
			'{ordtbl_pkg::OP_INSERT, 32'hFFFF_FFFF, 5'd0,  1'b1,
				'{ordtbl_pkg::ST_OK, 5'd0, 5'd3}},
			'{ordtbl_pkg::OP_SEARCH, 32'h7FFF_FFFF, 5'd0,  1'b0, NO_WANT},
			'{ordtbl_pkg::OP_INSERT, 32'h7FFF_FFFF, 5'd3,  1'b0, NO_WANT},
			'{ordtbl_pkg::OP_REMOVE, 32'h7FFF_FFFF, 5'd0,  1'b0, NO_WANT},
			'{ordtbl_pkg::OP_INSERT, 32'h0000_0000, 5'd0,  1'b0, NO_WANT},
			'{ordtbl_pkg::OP_INSERT, 32'h0000_0001, 5'd4,  1'b0, NO_WANT},
			'{ordtbl_pkg::OP_INSERT, 32'h5555_5555, 5'd2,  1'b0, NO_WANT},
			'{ordtbl_pkg::OP_INSERT, 32'hAAAA_AAAA, 5'd6,  1'b0, NO_WANT},
			'{ordtbl_pkg::OP_INSERT, 32'h8000_0001, 5'd1,  1'b0, NO_WANT},
			'{ordtbl_pkg::OP_INSERT, 32'h7FFF_FFFE, 5'd8,  1'b0, NO_WANT},
			'{ordtbl_pkg::OP_INSERT, 32'h0000_0000, 5'd3,  1'b0, NO_WANT},
			'{ordtbl_pkg::OP_INSERT, 32'hFFFF_FFFE, 5'd10, 1'b0, NO_WANT},
			'{ordtbl_pkg::OP_INSERT, 32'h0001_0000, 5'd5,  1'b0, NO_WANT},
			'{ordtbl_pkg::OP_INSERT, 32'hDEAD_BEEF, 5'd12, 1'b0, NO_WANT},
			'{ordtbl_pkg::OP_INSERT, 32'h8000_0000, 5'd0,  1'b0, NO_WANT},
			'{ordtbl_pkg::OP_INSERT, 32'h0F0F_0F0F, 5'd14, 1'b0, NO_WANT},
			'{ordtbl_pkg::OP_INSERT, 32'h1234_5678, 5'd15, 1'b0, NO_WANT},
			'{ordtbl_pkg::OP_INSERT, 32'h0000_0009, 5'd3,  1'b1,
				'{ordtbl_pkg::ST_FULL, ordtbl_pkg::NO_INDEX, 5'd16}},
			'{ordtbl_pkg::OP_SEARCH, 32'h0BAD_F00D, 5'd0,  1'b1,
				'{ordtbl_pkg::ST_NOT_FOUND, ordtbl_pkg::NO_INDEX, 5'd16}},
			'{ordtbl_pkg::OP_REMOVE, 32'h1234_5678, 5'd0,  1'b0, NO_WANT},
			'{ordtbl_pkg::OP_UNUSED, 32'hFFFF_FFFF, 5'd31, 1'b1,
				'{ordtbl_pkg::ST_BAD_POS, ordtbl_pkg::NO_INDEX, 5'd15}}
		};

		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (dir_rows[i])
			send_word(dir_rows[i].op, dir_rows[i].v, dir_rows[i].pos,
				dir_rows[i].typed, dir_rows[i].want);

		// random words in phases of different sender idling
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				1:       idle_pct = 84;
				3:       idle_pct = 33;
				default: idle_pct = 0;
			endcase
			for (int n = 0; n < RAND_PER_PHASE; n++) begin
				sender_gap(idle_pct);
				pick_word(op, v, p);
				send_word(op, v, p, 1'b0, NO_WANT);
			end
		end
		start <= 1'b0;

		while (owed_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("words sent: %0d search, %0d remove, %0d insert, %0d unused code",
			n_search, n_remove, n_insert, n_unused);
		$display("results seen: %0d ok, %0d not found, %0d full, %0d bad position",
			n_ok, n_miss, n_full, n_badpos);
		if (err_cnt == 0)
			$display("[ordered_table_insert_remove_search_core] OK");
		else
			$display("[ordered_table_insert_remove_search_core] ERROR");
		$finish;
	end

endmodule

### filelist.f
src/ordtbl_pkg.sv
src/ordtbl_cell.sv
src/ordered_table_insert_remove_search_core.sv
sim/ordered_table_insert_remove_search_core_tb.sv
